@@ design/bpsw_pkg.sv @@
// shared types, codes and constants for the bipolar pulse sequencer
package bpsw_pkg;

	// counter widths
	localparam int WIDTH_BITS = 16;
	localparam int IDLE_BITS  = 25;
	localparam int DEAD_BITS  = 8;

	// command codes carried by the mode field
	localparam logic [1:0] MODE_TICK    = 2'd0;
	localparam logic [1:0] MODE_ENABLE  = 2'd1;
	localparam logic [1:0] MODE_DISABLE = 2'd2;
	localparam logic [1:0] MODE_FIRE    = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEAD_DEAD = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MID_DEAD  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_TMO  = 2'd2;

	// configuration reset values
	localparam logic [DEAD_BITS-1:0] LEAD_DEAD_RST = 8'd1;
	localparam logic [DEAD_BITS-1:0] MID_DEAD_RST  = 8'd2;
	localparam logic [IDLE_BITS-1:0] IDLE_TMO_RST  = 25'd30000000;

	// live configuration seen by the sequencer
	typedef struct packed {
		logic [DEAD_BITS-1:0] lead_dead_us;
		logic [DEAD_BITS-1:0] mid_dead_us;
		logic [IDLE_BITS-1:0] idle_timeout_us;
	} cfg_t;

	// one result beat
	typedef struct packed {
		logic high_side_a;
		logic high_side_b;
		logic low_side_a;
		logic low_side_b;
		logic supply_enable;
		logic busy_res;
		logic fire_rejected;
		logic watchdog_tripped;
	} res_t;

endpackage

@@ design/bpsw_cfg.sv @@
// configuration register file for the pulse sequencer
module bpsw_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bpsw_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [bpsw_pkg::IDLE_BITS-1:0]      cfg_data,
	output bpsw_pkg::cfg_t                      cfg
);
	import bpsw_pkg::*;

	cfg_t cfg_q;

	// always able to take a write
	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// register writes by index, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lead_dead_us    <= LEAD_DEAD_RST;
			cfg_q.mid_dead_us     <= MID_DEAD_RST;
			cfg_q.idle_timeout_us <= IDLE_TMO_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LEAD_DEAD: cfg_q.lead_dead_us    <= cfg_data[DEAD_BITS-1:0];
				REG_MID_DEAD:  cfg_q.mid_dead_us     <= cfg_data[DEAD_BITS-1:0];
				REG_IDLE_TMO:  cfg_q.idle_timeout_us <= cfg_data;
				default:       ;
			endcase
		end
	end

endmodule

@@ design/bpsw_core.sv @@
// sequencer state and per-command next-state logic
module bpsw_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [1:0]                        mode,
	input  logic [bpsw_pkg::WIDTH_BITS-1:0]   pulse_width,
	input  bpsw_pkg::cfg_t                    cfg,
	output bpsw_pkg::res_t                    res
);
	import bpsw_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_POS,
		PH_MID,
		PH_NEG
	} phase_t;

	phase_t                phase_q, phase_n;
	logic [WIDTH_BITS-1:0] phase_count_q, phase_count_n;
	logic [WIDTH_BITS-1:0] width_hold_q, width_hold_n;
	logic [IDLE_BITS-1:0]  idle_count_q, idle_count_n;
	logic                  supply_on_q, supply_on_n;
	logic [WIDTH_BITS-1:0] count_inc;
	logic [WIDTH_BITS-1:0] cur_len;
	logic [IDLE_BITS-1:0]  idle_inc;
	logic                  rejected;
	logic                  tripped;
	phase_t                adv_phase;
	phase_t                fire_phase;

	// next phase with a nonzero length after p, or idle
	function automatic phase_t next_phase(input phase_t p,
			input logic [DEAD_BITS-1:0] lead, input logic [DEAD_BITS-1:0] mid,
			input logic [WIDTH_BITS-1:0] w);
		phase_t r;
		r = PH_IDLE;
		unique case (p)
			PH_IDLE: begin
				if (lead != '0)    r = PH_LEAD;
				else if (w != '0)  r = PH_POS;
				else if (mid != '0) r = PH_MID;
				else               r = PH_IDLE;
			end
			PH_LEAD: begin
				if (w != '0)        r = PH_POS;
				else if (mid != '0) r = PH_MID;
				else                r = PH_IDLE;
			end
			PH_POS: begin
				if (mid != '0)    r = PH_MID;
				else if (w != '0) r = PH_NEG;
				else              r = PH_IDLE;
			end
			PH_MID: begin
				if (w != '0) r = PH_NEG;
				else         r = PH_IDLE;
			end
			default: r = PH_IDLE;
		endcase
		return r;
	endfunction

	// length of the running phase
	always_comb begin
		case (phase_q)
			PH_LEAD:        cur_len = {{(WIDTH_BITS-DEAD_BITS){1'b0}}, cfg.lead_dead_us};
			PH_MID:         cur_len = {{(WIDTH_BITS-DEAD_BITS){1'b0}}, cfg.mid_dead_us};
			PH_POS, PH_NEG: cur_len = width_hold_q;
			default:        cur_len = '0;
		endcase
	end

	assign count_inc  = phase_count_q + 1'b1;
	assign idle_inc   = (idle_count_q != '1) ? idle_count_q + 1'b1 : idle_count_q;
	assign adv_phase  = next_phase(phase_q, cfg.lead_dead_us, cfg.mid_dead_us, width_hold_q);
	assign fire_phase = next_phase(PH_IDLE, cfg.lead_dead_us, cfg.mid_dead_us, pulse_width);

	// per-command state update
	always_comb begin
		phase_n       = phase_q;
		phase_count_n = phase_count_q;
		width_hold_n  = width_hold_q;
		idle_count_n  = idle_count_q;
		supply_on_n   = supply_on_q;
		rejected      = 1'b0;
		tripped       = 1'b0;
		unique case (mode)
			MODE_TICK: begin
				if (phase_q != PH_IDLE) begin
					phase_count_n = count_inc;
					if (count_inc >= cur_len) begin
						phase_count_n = '0;
						phase_n       = adv_phase;
						if (adv_phase == PH_IDLE) idle_count_n = '0;
					end
				end else if (supply_on_q) begin
					idle_count_n = idle_inc;
					if (idle_inc > cfg.idle_timeout_us) begin
						supply_on_n  = 1'b0;
						idle_count_n = '0;
						tripped      = 1'b1;
					end
				end
			end
			MODE_ENABLE: begin
				supply_on_n  = 1'b1;
				idle_count_n = '0;
			end
			MODE_DISABLE: begin
				supply_on_n   = 1'b0;
				phase_n       = PH_IDLE;
				phase_count_n = '0;
				idle_count_n  = '0;
			end
			MODE_FIRE: begin
				if (!supply_on_q || phase_q != PH_IDLE) begin
					rejected = 1'b1;
				end else begin
					width_hold_n  = pulse_width;
					phase_count_n = '0;
					phase_n       = fire_phase;
					if (fire_phase == PH_IDLE) idle_count_n = '0;
				end
			end
			default: ;
		endcase
	end

	// result fields follow the state after this command
	always_comb begin
		res.high_side_a      = (phase_n == PH_POS);
		res.low_side_b       = (phase_n == PH_POS);
		res.high_side_b      = (phase_n == PH_NEG);
		res.low_side_a       = (phase_n == PH_NEG);
		res.supply_enable    = supply_on_n;
		res.busy_res         = (phase_n != PH_IDLE);
		res.fire_rejected    = rejected;
		res.watchdog_tripped = tripped;
	end

	// state registers, advanced once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			phase_count_q <= '0;
			width_hold_q  <= '0;
			idle_count_q  <= '0;
			supply_on_q   <= 1'b0;
		end else if (accept) begin
			phase_q       <= phase_n;
			phase_count_q <= phase_count_n;
			width_hold_q  <= width_hold_n;
			idle_count_q  <= idle_count_n;
			supply_on_q   <= supply_on_n;
		end
	end

endmodule

@@ design/bpsw_out.sv @@
// result register between the sequencer and the output channel
module bpsw_out (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  bpsw_pkg::res_t  res,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            free,
	output bpsw_pkg::res_t  out_res
);
	import bpsw_pkg::*;

	logic out_valid_q;
	res_t res_q;

	// room for a new beat when empty or draining this cycle
	assign free      = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load || (out_valid_q && out_stall);
		end
	end

	// payload, held while stalled
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

@@ design/bipolar_pulse_sequencer_watchdog.sv @@
// top level of the bipolar pulse sequencer with idle watchdog
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | mode, pulse_width
//  out     | out_valid / out_stall| gate drives, supply_enable, busy_res, flags
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one command per cycle while in_stall is low; its result shows in the cycle after acceptance
// the state update and result compute sit between the state registers and
// the result register, so throughput is one beat per clock unless out_stall holds a result
// in_stall rises only while a result is held and out_stall is high
// reset puts the supply off, the sequencer idle and the config registers at defaults
module bipolar_pulse_sequencer_watchdog (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        mode,
	input  logic [bpsw_pkg::WIDTH_BITS-1:0]   pulse_width,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              high_side_a,
	output logic                              high_side_b,
	output logic                              low_side_a,
	output logic                              low_side_b,
	output logic                              supply_enable,
	output logic                              busy_res,
	output logic                              fire_rejected,
	output logic                              watchdog_tripped,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bpsw_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [bpsw_pkg::IDLE_BITS-1:0]    cfg_data
);
	import bpsw_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t out_res;
	logic free;
	logic accept;

	assign in_stall = !free;
	assign accept   = in_valid && free;

	// configuration registers
	bpsw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer state and next-state logic
	bpsw_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.mode        (mode),
		.pulse_width (pulse_width),
		.cfg         (cfg),
		.res         (res)
	);

	// result register
	bpsw_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res       (res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.free      (free),
		.out_res   (out_res)
	);

	assign high_side_a      = out_res.high_side_a;
	assign high_side_b      = out_res.high_side_b;
	assign low_side_a       = out_res.low_side_a;
	assign low_side_b       = out_res.low_side_b;
	assign supply_enable    = out_res.supply_enable;
	assign busy_res         = out_res.busy_res;
	assign fire_rejected    = out_res.fire_rejected;
	assign watchdog_tripped = out_res.watchdog_tripped;

endmodule

@@ design/bpsw_checker.sv @@
// port-level checks for the pulse sequencer, bound to the top level
module bpsw_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic high_side_a,
	input logic high_side_b,
	input logic low_side_a,
	input logic low_side_b,
	input logic supply_enable,
	input logic busy_res,
	input logic fire_rejected,
	input logic watchdog_tripped
);

	// a stalled result beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(high_side_a) && $stable(high_side_b)
			&& $stable(supply_enable) && $stable(busy_res))
		else $error("stalled result beat changed");

	// gates drive diagonally and never shoot through
	a_gates: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (high_side_a == low_side_b) && (high_side_b == low_side_a)
			&& !(high_side_a && high_side_b))
		else $error("gate drive pattern broken");

	// a running sequence needs the supply on
	a_busy_supply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && busy_res |-> supply_enable)
		else $error("sequence running with supply off");

	// a watchdog trip leaves the supply off and the bridge idle
	a_trip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && watchdog_tripped |-> !supply_enable && !busy_res && !fire_rejected)
		else $error("watchdog trip with supply or sequence active");

endmodule

bind bipolar_pulse_sequencer_watchdog bpsw_checker u_bpsw_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.high_side_a      (high_side_a),
	.high_side_b      (high_side_b),
	.low_side_a       (low_side_a),
	.low_side_b       (low_side_b),
	.supply_enable    (supply_enable),
	.busy_res         (busy_res),
	.fire_rejected    (fire_rejected),
	.watchdog_tripped (watchdog_tripped)
);

@@ test/bpsw_checker.sv @@
// result checker for the bipolar pulse sequencer: predicts every result beat and compares it
`timescale 1ns / 1ps
module bpsw_scoreboard (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [1:0]                        mode,
	input  logic [bpsw_pkg::WIDTH_BITS-1:0]   pulse_width,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic                              high_side_a,
	input  logic                              high_side_b,
	input  logic                              low_side_a,
	input  logic                              low_side_b,
	input  logic                              supply_enable,
	input  logic                              busy_res,
	input  logic                              fire_rejected,
	input  logic                              watchdog_tripped,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [bpsw_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [bpsw_pkg::IDLE_BITS-1:0]    cfg_data,
	output int                                fail_count,
	output int                                pending
);
	import bpsw_pkg::*;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_LEAD,
		SEQ_POS,
		SEQ_MID,
		SEQ_NEG
	} seq_phase_t;

	// timing registers as the block should hold them
	logic [DEAD_BITS-1:0]  lead_us;
	logic [DEAD_BITS-1:0]  mid_us;
	logic [IDLE_BITS-1:0]  tmo_us;

	// sequencer state
	logic                  sup_on;
	seq_phase_t            seq_ph;
	logic [WIDTH_BITS-1:0] seq_cnt;
	logic [WIDTH_BITS-1:0] held_width;
	logic [IDLE_BITS-1:0]  idle_cnt;

	res_t gate_states_q[$];

	// length of a phase in ticks
	function automatic logic [WIDTH_BITS-1:0] span_of(seq_phase_t p);
		case (p)
			SEQ_LEAD: return WIDTH_BITS'(lead_us);
			SEQ_MID:  return WIDTH_BITS'(mid_us);
			SEQ_POS,
			SEQ_NEG:  return held_width;
			default:  return '0;
		endcase
	endfunction

	// step to the next phase with a nonzero length, or finish the sequence
	task automatic enter_after(seq_phase_t p);
		int k;
		k = int'(p) + 1;
		while (k <= int'(SEQ_NEG) && span_of(seq_phase_t'(k)) == '0)
			k++;
		seq_cnt = '0;
		if (k > int'(SEQ_NEG)) begin
			seq_ph   = SEQ_IDLE;
			idle_cnt = '0;
		end else begin
			seq_ph = seq_phase_t'(k);
		end
	endtask

	// apply one command and form the gate states that follow it
	task automatic apply_command(input logic [1:0] m, input logic [WIDTH_BITS-1:0] w,
			output res_t r);
		logic rejected;
		logic tripped;
		rejected = 1'b0;
		tripped  = 1'b0;
		case (m)
			MODE_TICK: begin
				if (seq_ph != SEQ_IDLE) begin
					seq_cnt = seq_cnt + 1'b1;
					if (seq_cnt >= span_of(seq_ph))
						enter_after(seq_ph);
				end else if (sup_on) begin
					// idle count saturates at full scale
					if (idle_cnt != '1)
						idle_cnt = idle_cnt + 1'b1;
					if (idle_cnt > tmo_us) begin
						sup_on   = 1'b0;
						idle_cnt = '0;
						tripped  = 1'b1;
					end
				end
			end
			MODE_ENABLE: begin
				sup_on   = 1'b1;
				idle_cnt = '0;
			end
			MODE_DISABLE: begin
				sup_on   = 1'b0;
				seq_ph   = SEQ_IDLE;
				seq_cnt  = '0;
				idle_cnt = '0;
			end
			default: begin
				if (!sup_on || seq_ph != SEQ_IDLE) begin
					rejected = 1'b1;
				end else begin
					held_width = w;
					enter_after(SEQ_IDLE);
				end
			end
		endcase
		r.high_side_a      = (seq_ph == SEQ_POS);
		r.high_side_b      = (seq_ph == SEQ_NEG);
		r.low_side_a       = (seq_ph == SEQ_NEG);
		r.low_side_b       = (seq_ph == SEQ_POS);
		r.supply_enable    = sup_on;
		r.busy_res         = (seq_ph != SEQ_IDLE);
		r.fire_rejected    = rejected;
		r.watchdog_tripped = tripped;
	endtask

	task automatic check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// retire result beats first, then predict the command taken on the same edge
	always @(posedge clk or negedge arst_n) begin : track
		res_t want;
		if (!arst_n) begin
			lead_us    = LEAD_DEAD_RST;
			mid_us     = MID_DEAD_RST;
			tmo_us     = IDLE_TMO_RST;
			sup_on     = 1'b0;
			seq_ph     = SEQ_IDLE;
			seq_cnt    = '0;
			held_width = '0;
			idle_cnt   = '0;
			gate_states_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (gate_states_q.size() == 0) begin
					$error("result beat arrived with nothing expected");
					fail_count++;
				end else begin
					want = gate_states_q.pop_front();
					check_field("high_side_a", want.high_side_a, high_side_a);
					check_field("high_side_b", want.high_side_b, high_side_b);
					check_field("low_side_a", want.low_side_a, low_side_a);
					check_field("low_side_b", want.low_side_b, low_side_b);
					check_field("supply_enable", want.supply_enable, supply_enable);
					check_field("busy_res", want.busy_res, busy_res);
					check_field("fire_rejected", want.fire_rejected, fire_rejected);
					check_field("watchdog_tripped", want.watchdog_tripped,
						watchdog_tripped);
				end
			end
			if (in_valid && !in_stall) begin
				apply_command(mode, pulse_width, want);
				gate_states_q.push_back(want);
			end
			// a register write on this edge only affects later commands
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LEAD_DEAD: lead_us = cfg_data[DEAD_BITS-1:0];
					REG_MID_DEAD:  mid_us  = cfg_data[DEAD_BITS-1:0];
					REG_IDLE_TMO:  tmo_us  = cfg_data;
					default: ;
				endcase
			end
			pending = gate_states_q.size();
		end
	end

endmodule

@@ test/testbench.sv @@
// top of the sequencer testbench: clock, reset, command traffic and the verdict
`timescale 1ns / 1ps
module testbench;
	import bpsw_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [1:0]              mode = MODE_TICK;
	logic [WIDTH_BITS-1:0]   pulse_width = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    high_side_a;
	logic                    high_side_b;
	logic                    low_side_a;
	logic                    low_side_b;
	logic                    supply_enable;
	logic                    busy_res;
	logic                    fire_rejected;
	logic                    watchdog_tripped;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = REG_LEAD_DEAD;
	logic [IDLE_BITS-1:0]    cfg_data = '0;

	int mismatches;
	int pending_results;

	// traffic shaping knobs
	int stall_pct = 0;
	int stall_run = 0;
	logic stall_now = 1'b0;
	logic gaps_on = 1'b1;
	int burst_left = 0;
	int quiet_cycles = 0;
	int cur_lead = LEAD_DEAD_RST;
	int cur_mid = MID_DEAD_RST;

	bipolar_pulse_sequencer_watchdog dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.pulse_width(pulse_width),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.high_side_a(high_side_a),
		.high_side_b(high_side_b),
		.low_side_a(low_side_a),
		.low_side_b(low_side_b),
		.supply_enable(supply_enable),
		.busy_res(busy_res),
		.fire_rejected(fire_rejected),
		.watchdog_tripped(watchdog_tripped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	bpsw_scoreboard gate_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.pulse_width(pulse_width),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.high_side_a(high_side_a),
		.high_side_b(high_side_b),
		.low_side_a(low_side_a),
		.low_side_b(low_side_b),
		.supply_enable(supply_enable),
		.busy_res(busy_res),
		.fire_rejected(fire_rejected),
		.watchdog_tripped(watchdog_tripped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(mismatches),
		.pending(pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver stalls in runs of random length
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_now = ($urandom_range(0, 99) < stall_pct);
			stall_run = $urandom_range(1, 8);
		end
		stall_run--;
		out_stall <= stall_now;
	end

	// hang detection: any beat on any channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// one command beat, sent in bursts with random gaps between them when gaps_on is set
	task automatic send_command(input logic [1:0] m, input logic [WIDTH_BITS-1:0] w);
		int gap;
		if (gaps_on && burst_left == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		pulse_width <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		if (burst_left > 0)
			burst_left--;
	endtask

	// hold off the sender until every result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_results != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [IDLE_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// dead times carry random junk above bit 7, which the block must drop
	task automatic program_timing(input int lead, input int mid,
			input logic [IDLE_BITS-1:0] tmo, input logic poke_spare);
		write_reg(REG_LEAD_DEAD, IDLE_BITS'({$urandom(), DEAD_BITS'(lead)}));
		write_reg(REG_MID_DEAD, IDLE_BITS'({$urandom(), DEAD_BITS'(mid)}));
		write_reg(REG_IDLE_TMO, tmo);
		if (poke_spare)
			write_reg(REG_SPARE, IDLE_BITS'($urandom()));
		cfg_valid <= 1'b0;
		cur_lead = lead;
		cur_mid  = mid;
	endtask

	// mostly arm, fire and tick through the sequence; the rest is noise
	task automatic run_mixed_traffic(input int n_items, input int max_w, input int tick_cap);
		int sent;
		int span;
		int ticks;
		logic [WIDTH_BITS-1:0] w;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 80) begin
				if ($urandom_range(0, 3) != 0) begin
					send_command(MODE_ENABLE, WIDTH_BITS'($urandom()));
					sent++;
				end
				if ($urandom_range(0, 15) == 0)
					w = WIDTH_BITS'($urandom());
				else
					w = WIDTH_BITS'($urandom_range(0, max_w));
				send_command(MODE_FIRE, w);
				sent++;
				span  = cur_lead + cur_mid + 2 * int'(w);
				ticks = (span < tick_cap ? span : tick_cap) + $urandom_range(0, 12);
				if ($urandom_range(0, 3) == 0)
					ticks = $urandom_range(0, ticks);
				// keep the phase within its item budget
				if (ticks > n_items - sent)
					ticks = (n_items > sent) ? n_items - sent : 0;
				repeat (ticks) begin
					// stray enable or fire in the middle of a sequence
					if ($urandom_range(0, 49) == 0)
						send_command($urandom_range(0, 1) ? MODE_ENABLE : MODE_FIRE,
							WIDTH_BITS'($urandom()));
					else
						send_command(MODE_TICK, WIDTH_BITS'($urandom()));
					sent++;
				end
			end else begin
				send_command(2'($urandom()), WIDTH_BITS'($urandom()));
				sent++;
			end
			if ($urandom_range(0, 99) == 0)
				drain_results();
		end
	endtask

	initial begin
		stall_pct = 25;
		gaps_on   = 1'b1;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset timing, lead 1 and mid 2
		send_command(MODE_TICK, 16'hFFFF);
		send_command(MODE_FIRE, 16'd3);
		send_command(MODE_ENABLE, 16'd0);
		send_command(MODE_FIRE, 16'd2);
		send_command(MODE_FIRE, 16'd1);
		repeat (3) send_command(MODE_TICK, 16'd0);
		send_command(MODE_ENABLE, 16'hFFFF);
		repeat (5) send_command(MODE_TICK, 16'd0);
		// widest pulse, cut short by disable
		send_command(MODE_FIRE, 16'hFFFF);
		repeat (3) send_command(MODE_TICK, 16'hFFFF);
		send_command(MODE_DISABLE, 16'd0);
		send_command(MODE_FIRE, 16'd0);
		send_command(MODE_ENABLE, 16'd0);
		// zero width: only the dead times run
		send_command(MODE_FIRE, 16'd0);
		repeat (3) send_command(MODE_TICK, 16'd0);
		drain_results();

		// no dead time, instant timeout, no idling on either side
		stall_pct = 0;
		gaps_on   = 1'b0;
		program_timing(0, 0, '0, 1'b0);
		run_mixed_traffic(100, 4, 40);
		drain_results();

		// short timeout with moderate back pressure
		stall_pct = 30;
		gaps_on   = 1'b1;
		program_timing(3, 1, IDLE_BITS'(5), 1'b0);
		run_mixed_traffic(170, 6, 60);
		drain_results();

		// longest dead times, timeout that can never expire
		stall_pct = 20;
		program_timing(255, 255, '1, 1'b0);
		run_mixed_traffic(540, 3, 600);
		drain_results();

		// random timing plus a write to the unused register index
		stall_pct = 55;
		program_timing($urandom_range(0, 6), $urandom_range(0, 6),
			IDLE_BITS'($urandom_range(0, 12)), 1'b1);
		run_mixed_traffic(160, 8, 80);
		drain_results();

		stall_pct = 10;
		program_timing(1, 0, IDLE_BITS'(2), 1'b0);
		run_mixed_traffic(100, 5, 50);
		drain_results();

		repeat (16) @(negedge clk);
		if (mismatches == 0 && pending_results == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
